// ===== src/trle_pkg.sv =====
`default_nettype none
package trle_pkg;

    localparam int TILE_SIZE     = 64;
    localparam int TILE_LIMIT    = (TILE_SIZE < 64) ? TILE_SIZE : 64;
    localparam int PALETTE_DEPTH = 16;
    localparam int PAL_AW        = $clog2(PALETTE_DEPTH);
    localparam int RUN_MAX       = 8191;

    localparam logic [7:0] SUB_RAW   = 8'd0;
    localparam logic [7:0] SUB_SOLID = 8'd1;
    localparam logic [7:0] SUB_RLE   = 8'd128;
    localparam logic [7:0] SUB_PRLE  = 8'd128;
    localparam logic [7:0] RUN_CONT  = 8'd255;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_SUBENC  = 2'd1;
    localparam logic [1:0] ERR_INDEX   = 2'd2;
    localparam logic [1:0] ERR_OVERRUN = 2'd3;

    localparam logic CFG_CPIXEL = 1'b0;
    localparam logic CFG_ENDIAN = 1'b1;

    localparam logic ACT_START = 1'b0;

    typedef enum logic [3:0] {
        PH_IDLE, PH_SUBENC, PH_RAW, PH_SOLID, PH_PACK_PAL, PH_PACK_ROWS,
        PH_RLE_PIX, PH_RLE_RUN, PH_PRLE_PAL, PH_PRLE_INDEX, PH_PRLE_RUN
    } phase_t;

    typedef enum logic [2:0] {
        CT_IN, CT_PAINT, CT_PACK, CT_PRD, CT_IDX
    } ctl_t;

endpackage
`default_nettype wire

// ===== src/trle_ram.sv =====
`default_nettype none
module trle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

// ===== src/trle_tile_decoder_unit.sv =====
// a result is registered into the output register in the cycle after the item or step causing it
// throughput: one byte per cycle while the output register is free and the unit is taking
// input; input stalls while spans of raw pixels, runs, solid fills and palette-rle indices
// are painted, while palette ram reads complete and while packed pixels are emitted
// reset: synchronous active-low aresetn clears control state, phase waits for tile start;
// palette contents are undefined until written and are only read after being written
`default_nettype none
module trle_tile_decoder_unit
    import trle_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,  // tile_width, tile_height, data_byte
    input  wire logic        s_tuser,  // action
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // span_x, span_y, span_length, pixel_value, error_code, tile_done
    output logic [55:0]      m_tdata,
    output logic             m_tlast,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [2:0]  cfg_wdata
);
    logic [2:0]  cpix_reg;
    logic        bige_reg;
    phase_t      phase_reg, phase_next;
    ctl_t        ctl_reg, ctl_next;
    logic [4:0]  psize_reg, psize_next;
    logic [4:0]  pfill_reg, pfill_next;
    logic [31:0] acc_reg, acc_next;
    logic [2:0]  pcnt_reg, pcnt_next;
    logic [5:0]  cx_reg, cx_next;
    logic [5:0]  cy_reg, cy_next;
    logic [12:0] run_reg, run_next;
    logic [31:0] cur_reg, cur_next;
    logic [5:0]  tw_reg, tw_next;
    logic [5:0]  th_reg, th_next;
    logic [13:0] plen_reg, plen_next;
    logic [7:0]  sr_reg, sr_next;
    logic [3:0]  pk_i_reg, pk_i_next;
    logic [3:0]  pk_n_reg, pk_n_next;
    logic        rflag_reg, rflag_next;

    logic        mv_reg;
    logic [55:0] md_reg;
    logic        ml_reg;

    logic        can_emit, in_acc;
    logic        emit, o_last, o_done;
    logic [5:0]  o_x, o_y;
    logic [6:0]  o_len;
    logic [31:0] o_pix;
    logic [1:0]  o_err;

    logic        ram_we, ram_re;
    logic [PAL_AW-1:0] ram_waddr, ram_raddr;
    logic [31:0] ram_rdata;

    logic [7:0]  byte_in;
    logic [2:0]  nb, pcnt_upd;
    logic [31:0] acc_upd;
    logic        pix_done;
    logic [6:0]  w7, h7, in_w, in_h, rowleft, seg, x_new, y_new;
    logic [13:0] rlen;
    logic [12:0] run_sat;
    logic [13:0] run_sum;
    logic [2:0]  fbits;
    logic [3:0]  pk_idx, pk_max;
    logic [6:0]  avail;

    assign can_emit = !mv_reg || m_tready;
    assign s_tready = (ctl_reg == CT_IN) && can_emit;
    assign in_acc   = s_tvalid && s_tready;
    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign m_tlast  = ml_reg;
    assign byte_in  = s_tdata[21:14];

    assign w7 = {1'b0, tw_reg} + 7'd1;
    assign h7 = {1'b0, th_reg} + 7'd1;

    always_comb begin
        in_w = s_tdata[6:0];
        in_h = s_tdata[13:7];
        if (in_w == 7'd0) in_w = 7'd1;
        if (in_h == 7'd0) in_h = 7'd1;
        if (in_w > 7'(TILE_LIMIT)) in_w = 7'(TILE_LIMIT);
        if (in_h > 7'(TILE_LIMIT)) in_h = 7'(TILE_LIMIT);
    end

    always_comb begin
        if (cpix_reg == 3'd0) nb = 3'd1;
        else if (cpix_reg > 3'd4) nb = 3'd4;
        else nb = cpix_reg;
        if (bige_reg) acc_upd = {acc_reg[23:0], byte_in};
        else acc_upd = acc_reg | ({24'd0, byte_in} << {pcnt_reg[1:0], 3'd0});
        pcnt_upd = pcnt_reg + 3'd1;
        pix_done = pcnt_upd >= nb;
    end

    always_comb begin
        run_sum = {1'b0, run_reg} + 14'd255;
        run_sat = (run_sum > 14'(RUN_MAX)) ? 13'(RUN_MAX) : run_sum[12:0];
        rlen    = {1'b0, run_reg} + {6'd0, byte_in} + 14'd1;
    end

    always_comb begin
        if (psize_reg == 5'd2) fbits = 3'd1;
        else if (psize_reg <= 5'd4) fbits = 3'd2;
        else fbits = 3'd4;
        unique case (fbits)
            3'd1:    pk_idx = {3'd0, sr_reg[7]};
            3'd2:    pk_idx = {2'd0, sr_reg[7:6]};
            default: pk_idx = sr_reg[7:4];
        endcase
        avail  = w7 - {1'b0, cx_reg};
        pk_max = (fbits == 3'd1) ? 4'd8 : ((fbits == 3'd2) ? 4'd4 : 4'd2);
        if ({3'd0, pk_max} > avail) pk_max = avail[3:0];
    end

    always_comb begin
        rowleft = w7 - {1'b0, cx_reg};
        if (ctl_reg == CT_PRD) seg = 7'd1;
        else seg = (plen_reg < {7'd0, rowleft}) ? plen_reg[6:0] : rowleft;
        x_new   = {1'b0, cx_reg} + seg;
        y_new   = {1'b0, cy_reg} + 7'd1;
    end

    always_comb begin
        phase_next = phase_reg;
        ctl_next   = ctl_reg;
        psize_next = psize_reg;
        pfill_next = pfill_reg;
        acc_next   = acc_reg;
        pcnt_next  = pcnt_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        run_next   = run_reg;
        cur_next   = cur_reg;
        tw_next    = tw_reg;
        th_next    = th_reg;
        plen_next  = plen_reg;
        sr_next    = sr_reg;
        pk_i_next  = pk_i_reg;
        pk_n_next  = pk_n_reg;
        rflag_next = rflag_reg;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_waddr  = pfill_reg[PAL_AW-1:0];
        ram_raddr  = pk_idx[PAL_AW-1:0];
        emit       = 1'b0;
        o_x        = cx_reg;
        o_y        = cy_reg;
        o_len      = 7'd0;
        o_pix      = 32'd0;
        o_err      = ERR_NONE;
        o_done     = 1'b0;
        o_last     = 1'b0;
        unique case (ctl_reg)
            CT_IN: begin
                if (in_acc && s_tuser == ACT_START) begin
                    tw_next    = 6'(in_w - 7'd1);
                    th_next    = 6'(in_h - 7'd1);
                    phase_next = PH_SUBENC;
                    psize_next = 5'd0;
                    pfill_next = 5'd0;
                    acc_next   = 32'd0;
                    pcnt_next  = 3'd0;
                    cx_next    = 6'd0;
                    cy_next    = 6'd0;
                    run_next   = 13'd0;
                    cur_next   = 32'd0;
                end else if (in_acc) begin
                    unique case (phase_reg)
                        PH_SUBENC: begin
                            if (byte_in == SUB_RAW) begin
                                phase_next = PH_RAW;
                            end else if (byte_in == SUB_SOLID) begin
                                phase_next = PH_SOLID;
                            end else if (byte_in <= 8'd16) begin
                                psize_next = byte_in[4:0];
                                pfill_next = 5'd0;
                                phase_next = PH_PACK_PAL;
                            end else if (byte_in == SUB_RLE) begin
                                phase_next = PH_RLE_PIX;
                            end else if (byte_in >= 8'd130
                                         && byte_in - SUB_PRLE <= 8'(PALETTE_DEPTH)) begin
                                psize_next = 5'(byte_in - SUB_PRLE);
                                pfill_next = 5'd0;
                                phase_next = PH_PRLE_PAL;
                            end else begin
                                emit       = 1'b1;
                                o_err      = ERR_SUBENC;
                                o_last     = 1'b1;
                                phase_next = PH_IDLE;
                            end
                        end
                        PH_RAW, PH_SOLID, PH_PACK_PAL, PH_PRLE_PAL, PH_RLE_PIX: begin
                            acc_next  = acc_upd;
                            pcnt_next = pcnt_upd;
                            if (pix_done) begin
                                acc_next  = 32'd0;
                                pcnt_next = 3'd0;
                                cur_next  = acc_upd;
                                priority case (phase_reg)
                                    PH_RAW: begin
                                        plen_next = 14'd1;
                                        ctl_next  = CT_PAINT;
                                    end
                                    PH_SOLID: begin
                                        plen_next = 14'(w7 * h7);
                                        ctl_next  = CT_PAINT;
                                    end
                                    PH_RLE_PIX: begin
                                        run_next   = 13'd0;
                                        phase_next = PH_RLE_RUN;
                                    end
                                    default: begin
                                        ram_we     = 1'b1;
                                        pfill_next = pfill_reg + 5'd1;
                                        if (pfill_reg + 5'd1 >= psize_reg) begin
                                            phase_next = (phase_reg == PH_PACK_PAL)
                                                ? PH_PACK_ROWS : PH_PRLE_INDEX;
                                        end
                                    end
                                endcase
                            end
                        end
                        PH_RLE_RUN, PH_PRLE_RUN: begin
                            if (byte_in == RUN_CONT) begin
                                run_next = run_sat;
                            end else begin
                                run_next   = 13'd0;
                                plen_next  = rlen;
                                ctl_next   = CT_PAINT;
                                phase_next = (phase_reg == PH_RLE_RUN)
                                    ? PH_RLE_PIX : PH_PRLE_INDEX;
                            end
                        end
                        PH_PACK_ROWS: begin
                            sr_next   = byte_in;
                            pk_i_next = 4'd0;
                            pk_n_next = pk_max;
                            ctl_next  = CT_PACK;
                        end
                        PH_PRLE_INDEX: begin
                            if ({1'b0, byte_in[6:0]} >= {3'd0, psize_reg}) begin
                                emit       = 1'b1;
                                o_err      = ERR_INDEX;
                                o_last     = 1'b1;
                                phase_next = PH_IDLE;
                            end else begin
                                ram_re     = 1'b1;
                                ram_raddr  = byte_in[PAL_AW-1:0];
                                rflag_next = byte_in[7];
                                ctl_next   = CT_IDX;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            CT_IDX: begin
                if (rflag_reg) begin
                    cur_next   = ram_rdata;
                    run_next   = 13'd0;
                    phase_next = PH_PRLE_RUN;
                    ctl_next   = CT_IN;
                end else begin
                    cur_next  = ram_rdata;
                    plen_next = 14'd1;
                    ctl_next  = CT_PAINT;
                end
            end
            CT_PAINT: begin
                if (can_emit) begin
                    emit      = 1'b1;
                    o_len     = seg;
                    o_pix     = cur_reg;
                    plen_next = plen_reg - {7'd0, seg};
                    cx_next   = x_new[5:0];
                    if (x_new == w7) begin
                        cx_next = 6'd0;
                        cy_next = y_new[5:0];
                    end
                    if (x_new == w7 && y_new == h7) begin
                        cx_next    = 6'd0;
                        cy_next    = 6'd0;
                        o_done     = 1'b1;
                        o_last     = 1'b1;
                        o_err      = (plen_next != 14'd0) ? ERR_OVERRUN : ERR_NONE;
                        phase_next = PH_IDLE;
                        ctl_next   = CT_IN;
                    end else if (plen_next == 14'd0) begin
                        o_last   = 1'b1;
                        ctl_next = CT_IN;
                    end
                end
            end
            CT_PACK: begin
                if ({1'b0, pk_idx} >= psize_reg) begin
                    if (can_emit) begin
                        emit       = 1'b1;
                        o_err      = ERR_INDEX;
                        o_last     = 1'b1;
                        phase_next = PH_IDLE;
                        ctl_next   = CT_IN;
                    end
                end else begin
                    ram_re   = 1'b1;
                    ctl_next = CT_PRD;
                end
            end
            CT_PRD: begin
                if (can_emit) begin
                    emit      = 1'b1;
                    o_len     = 7'd1;
                    o_pix     = ram_rdata;
                    sr_next   = sr_reg << fbits;
                    pk_i_next = pk_i_reg + 4'd1;
                    cx_next   = x_new[5:0];
                    ctl_next  = CT_PACK;
                    if (x_new == w7) begin
                        cx_next = 6'd0;
                        cy_next = y_new[5:0];
                    end
                    if (x_new == w7 && y_new == h7) begin
                        cx_next    = 6'd0;
                        cy_next    = 6'd0;
                        o_done     = 1'b1;
                        o_last     = 1'b1;
                        phase_next = PH_IDLE;
                        ctl_next   = CT_IN;
                    end else if (pk_i_reg + 4'd1 == pk_n_reg) begin
                        o_last   = 1'b1;
                        ctl_next = CT_IN;
                    end
                end
            end
            default: ctl_next = CT_IN;
        endcase
    end

    trle_ram #(.WIDTH(32), .DEPTH(PALETTE_DEPTH)) u_palette (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (acc_upd),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cpix_reg  <= 3'd3;
            bige_reg  <= 1'b0;
            phase_reg <= PH_IDLE;
            ctl_reg   <= CT_IN;
            psize_reg <= 5'd0;
            pfill_reg <= 5'd0;
            acc_reg   <= 32'd0;
            pcnt_reg  <= 3'd0;
            cx_reg    <= 6'd0;
            cy_reg    <= 6'd0;
            run_reg   <= 13'd0;
            cur_reg   <= 32'd0;
            tw_reg    <= 6'd0;
            th_reg    <= 6'd0;
            mv_reg    <= 1'b0;
        end else begin
            if (cfg_we && cfg_index == CFG_CPIXEL) cpix_reg <= cfg_wdata;
            if (cfg_we && cfg_index == CFG_ENDIAN) bige_reg <= cfg_wdata[0];
            phase_reg <= phase_next;
            ctl_reg   <= ctl_next;
            psize_reg <= psize_next;
            pfill_reg <= pfill_next;
            acc_reg   <= acc_next;
            pcnt_reg  <= pcnt_next;
            cx_reg    <= cx_next;
            cy_reg    <= cy_next;
            run_reg   <= run_next;
            cur_reg   <= cur_next;
            tw_reg    <= tw_next;
            th_reg    <= th_next;
            if (emit) mv_reg <= 1'b1;
            else if (m_tready) mv_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        plen_reg  <= plen_next;
        sr_reg    <= sr_next;
        pk_i_reg  <= pk_i_next;
        pk_n_reg  <= pk_n_next;
        rflag_reg <= rflag_next;
        if (emit) begin
            md_reg <= {2'b00, o_done, o_err, o_pix, o_len, o_y, o_x};
            ml_reg <= o_last;
        end
    end

`ifndef SYNTHESIS
    a_pack_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl_reg == CT_PACK || ctl_reg == CT_PRD) |-> phase_reg == PH_PACK_ROWS)
        else $error("packed pixel walk outside packed rows");
    a_overrun_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[52:51] == ERR_OVERRUN) |-> (m_tdata[53] && m_tlast))
        else $error("overrun not on final span");
    a_cursor_in_tile: assert property (@(posedge aclk) disable iff (!aresetn)
        cx_reg <= tw_reg && cy_reg <= th_reg)
        else $error("cursor outside tile");
    a_emit_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> can_emit)
        else $error("result overwrites pending item");
`endif
endmodule
`default_nettype wire
